// ===== rtl/bloom_filter_byte_sum_unit_defines.svh =====
// assertion macros shared by the bloom filter byte sum checker
// no dependencies; include guard keeps it single-pass

`ifndef BLOOM_FILTER_BYTE_SUM_UNIT_DEFINES_SVH
`define BLOOM_FILTER_BYTE_SUM_UNIT_DEFINES_SVH

// same-cycle check, off while in reset
`define BFBS_ASSERT_NOW(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bfbs check failed");

// next-cycle implication, off while in reset
`define BFBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfbs check failed");

// next-cycle implication that also covers the reset cycles
`define BFBS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bfbs check failed");

`endif

// ===== rtl/bfbs_pkg.sv =====
// shared types and constants for the bloom filter byte sum unit
// no dependencies

package bfbs_pkg;

    localparam int SUM_W      = 24;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int FSIZE_W    = 9;
    localparam int NHASH_W    = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [FSIZE_W-1:0] FSIZE_RESET = 9'd100;
    localparam logic [NHASH_W-1:0] NHASH_RESET = 4'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES  = 8'd1;

    // operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_PROBE,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic div_step;
        logic probe_step;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic div_last;
        logic probes_done;
    } ctrl_status_t;

endpackage

// ===== rtl/bfbs_ram.sv =====
// generic single-port ram with registered read
// no dependencies

module bfbs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write or registered read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bfbs_ctrl.sv =====
// controller state machine for the bloom filter byte sum unit
// depends on bfbs_pkg

module bfbs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_last_byte,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bfbs_pkg::ctrl_cmd_t   cmd,
    input  bfbs_pkg::ctrl_status_t status
);

    import bfbs_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && s_last_byte) begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (status.probes_done) begin
                    state_next = ST_RESP;
                end else begin
                    cmd.probe_step = 1'b1;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/bfbs_datapath.sv =====
// datapath: configuration, byte sum, remainder unit, probe walk, bit store and result registers
// depends on bfbs_pkg and bfbs_ram

module bfbs_datapath #(
    parameter int FILTER_BITS = 256,
    parameter int MAX_HASHES  = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bfbs_pkg::ctrl_cmd_t               cmd,
    output bfbs_pkg::ctrl_status_t            status,
    input  logic                              cfg_valid,
    input  logic [bfbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfbs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_operation,
    input  logic [7:0]                        s_key_byte,
    input  logic                              s_last_byte,
    output logic                              m_maybe_present,
    output logic                              m_was_add
);

    import bfbs_pkg::*;

    // only positions below the 9-bit size register can ever be reached
    localparam int MEM_DEPTH = (FILTER_BITS < (1 << FSIZE_W)) ? FILTER_BITS : (1 << FSIZE_W);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(MAX_HASHES + 1);

    logic [FSIZE_W-1:0]   fsize_reg;
    logic [NHASH_W-1:0]   nhash_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_add;
    logic [SUM_W-1:0]     dvd_reg;
    logic [FSIZE_W-1:0]   rem_reg;
    logic [FSIZE_W:0]     rem_shift;
    logic [FSIZE_W-1:0]   rem_new;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 op_reg;
    logic [FSIZE_W-1:0]   size_use;
    logic [CNT_W-1:0]     probes_use;
    logic [FSIZE_W-1:0]   pos_reg;
    logic [FSIZE_W:0]     pos_inc;
    logic [FSIZE_W-1:0]   pos_next;
    logic [CNT_W-1:0]     hcnt_reg;
    logic                 rd_valid_reg;
    logic                 all_set_reg;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic                 maybe_reg;
    logic                 was_add_reg;
    logic                 ram_en;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic                 ram_wdata;
    logic                 ram_rdata;

    // clamped size and probe count
    always_comb begin
        if (fsize_reg == '0) begin
            size_use = FSIZE_W'(1);
        end else if (int'(fsize_reg) > FILTER_BITS) begin
            size_use = FSIZE_W'(FILTER_BITS);
        end else begin
            size_use = fsize_reg;
        end
        if (int'(nhash_reg) > MAX_HASHES) begin
            probes_use = CNT_W'(MAX_HASHES);
        end else begin
            probes_use = CNT_W'(nhash_reg);
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsize_reg <= FSIZE_RESET;
            nhash_reg <= NHASH_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FILTER_SIZE: fsize_reg <= cfg_data[FSIZE_W-1:0];
                CFG_NUM_HASHES:  nhash_reg <= cfg_data[NHASH_W-1:0];
                default: ;
            endcase
        end
    end

    // remainder step: one dividend bit per cycle
    assign sum_add   = sum_reg + SUM_W'(s_key_byte);
    assign rem_shift = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_new   = (rem_shift >= {1'b0, size_use})
                     ? FSIZE_W'(rem_shift - {1'b0, size_use})
                     : rem_shift[FSIZE_W-1:0];

    // wrap the probe position at the size in use
    assign pos_inc  = {1'b0, pos_reg} + (FSIZE_W + 1)'(1);
    assign pos_next = (pos_inc == {1'b0, size_use}) ? '0 : pos_inc[FSIZE_W-1:0];

    // control counters and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            div_cnt_reg  <= '0;
            hcnt_reg     <= '0;
            rd_valid_reg <= 1'b0;
            clr_cnt_reg  <= '0;
        end else begin
            rd_valid_reg <= cmd.probe_step && (op_reg == OP_QUERY);
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.accept) begin
                sum_reg     <= s_last_byte ? '0 : sum_add;
                div_cnt_reg <= '0;
            end
            if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                if (status.div_last) begin
                    hcnt_reg <= '0;
                end
            end
            if (cmd.probe_step) begin
                hcnt_reg <= hcnt_reg + CNT_W'(1);
            end
        end
    end

    // divider, probe walk and result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_last_byte) begin
            dvd_reg <= sum_add;
            rem_reg <= '0;
            op_reg  <= s_operation;
        end
        if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
            rem_reg <= rem_new;
            if (status.div_last) begin
                pos_reg     <= rem_new;
                all_set_reg <= 1'b1;
            end
        end
        if (cmd.probe_step) begin
            pos_reg <= pos_next;
        end
        if (rd_valid_reg && !ram_rdata) begin
            all_set_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            maybe_reg   <= (op_reg == OP_QUERY) ? all_set_reg : 1'b0;
            was_add_reg <= (op_reg == OP_ADD);
        end
    end

    // bit store port: clearing pass or probe
    always_comb begin
        ram_en    = cmd.clr_step || cmd.probe_step;
        ram_we    = cmd.clr_step || (op_reg == OP_ADD);
        ram_addr  = cmd.clr_step ? clr_cnt_reg : pos_reg[ADDR_W-1:0];
        ram_wdata = !cmd.clr_step;
    end

    bfbs_ram #(
        .WIDTH (1),
        .DEPTH (MEM_DEPTH)
    ) u_bits (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // status back to the controller
    assign status.clr_done    = (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1));
    assign status.div_last    = (div_cnt_reg == DIV_CNT_W'(SUM_W - 1));
    assign status.probes_done = (hcnt_reg == probes_use);

    assign m_maybe_present = maybe_reg;
    assign m_was_add       = was_add_reg;

endmodule

// ===== rtl/bloom_filter_byte_sum_unit.sv =====
// Bloom filter over byte-string keys with a byte-sum hash.
// Input channel (s_): one key byte per request with an add/query selector and a
// last-byte flag; every byte, the last included, is summed (24-bit, wrapping);
// bytes that are not last are taken one per cycle. Result channel (m_): one
// request per key, maybe_present (query hit) and was_add (acknowledges an add).
// Config channel (cfg_): index 0 filter_size, index 1 num_hashes; cfg_ready is
// always high, other indexes are dropped. Write only while the block is idle.
// Sequence: after the last byte is accepted, the sum is reduced modulo the size
// by a one-bit-per-cycle remainder unit, then the bit store is read or written
// once per probe (clamped num_hashes probes) and the last read is taken in; then
// the result loads into the output register, once it is free, and m_valid rises.
// The input is held off from the last byte until the result is loaded into the
// output register, so a new key is not taken before the last one is through.
// Reset: synchronous, active low. The bit store is then cleared one entry per
// cycle, all min(FILTER_BITS, 512) entries, with s_ready low during that pass.
// Stall: a pending result holds until m_ready; new bytes of the next key are
// still taken, and its result waits in the controller until the register frees.
// depends on bfbs_pkg, bfbs_ctrl, bfbs_datapath

module bloom_filter_byte_sum_unit #(
    parameter int FILTER_BITS = 256,
    parameter int MAX_HASHES  = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bfbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [7:0]                      s_key_byte,
    input  logic                            s_last_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_maybe_present,
    output logic                            m_was_add
);

    import bfbs_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // registers take writes every cycle
    assign cfg_ready = 1'b1;

    bfbs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_byte (s_last_byte),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    bfbs_datapath #(
        .FILTER_BITS (FILTER_BITS),
        .MAX_HASHES  (MAX_HASHES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_operation     (s_operation),
        .s_key_byte      (s_key_byte),
        .s_last_byte     (s_last_byte),
        .m_maybe_present (m_maybe_present),
        .m_was_add       (m_was_add)
    );

endmodule

// ===== rtl/bfbs_checker.sv =====
// port-level checks for the bloom filter byte sum unit, bound to the top level
// depends on bloom_filter_byte_sum_unit_defines.svh

`include "bloom_filter_byte_sum_unit_defines.svh"

module bfbs_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_last_byte,
    input logic m_valid,
    input logic m_ready,
    input logic m_maybe_present,
    input logic m_was_add
);

    // a stalled result request holds its payload
    `BFBS_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_maybe_present) && $stable(m_was_add))

    // an add never reports a hit
    `BFBS_ASSERT_NOW(a_add_no_hit, aclk, aresetn, !(m_valid && m_was_add && m_maybe_present))

    // the last byte of a key closes the input while the key is worked on
    `BFBS_ASSERT_NEXT(a_busy_after_last, aclk, aresetn, s_valid && s_ready && s_last_byte, !s_ready)

    // reset starts the clearing pass with no result pending
    `BFBS_ASSERT_NEXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !s_ready && !m_valid)

endmodule

bind bloom_filter_byte_sum_unit bfbs_checker u_bfbs_checker (.*);

// ===== test/bloom_filter_byte_sum_unit_tb.sv =====
// testbench for bloom_filter_byte_sum_unit: keys streamed byte by byte, results
// checked against an in-bench bloom filter model; depends on bfbs_pkg and the rtl

module bloom_filter_byte_sum_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfbs_pkg::*;

    localparam int FILTER_BITS  = 256;
    localparam int MAX_HASHES   = 8;
    localparam int RANDOM_ITEMS = 1050;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int IDLE_PCT     = 22;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_NUM_HASHES + 1'b1;

    typedef struct packed {
        logic maybe_present;
        logic was_add;
    } bloom_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_operation;
    logic [7:0]            s_key_byte;
    logic                  s_last_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_maybe_present;
    logic                  m_was_add;

    // filter model state
    bit [FILTER_BITS-1:0]  filter_bits;
    bit [SUM_W-1:0]        key_sum;
    bit [FSIZE_W-1:0]      filter_size;
    bit [NHASH_W-1:0]      num_hashes;

    bloom_result_t         pending_results[$];
    int                    added_sums[$];
    int                    error_count;
    int                    bytes_sent;
    int                    cycle_count;
    bit                    steady;

    bloom_filter_byte_sum_unit #(
        .FILTER_BITS(FILTER_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_key_byte     (s_key_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_maybe_present(m_maybe_present),
        .m_was_add      (m_was_add)
    );

    // clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bloom_filter_byte_sum_unit_tb failed");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // result checker
    always @(posedge aclk) begin
        bloom_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got maybe_present=%0b was_add=%0b",
                         $realtime, m_maybe_present, m_was_add);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_maybe_present !== exp_res.maybe_present) begin
                    $display("%0t: maybe_present mismatch, expected %0b, got %0b",
                             $realtime, exp_res.maybe_present, m_maybe_present);
                    error_count++;
                end
                if (m_was_add !== exp_res.was_add) begin
                    $display("%0t: was_add mismatch, expected %0b, got %0b",
                             $realtime, exp_res.was_add, m_was_add);
                    error_count++;
                end
            end
        end
    end

    // model: apply a register write
    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_FILTER_SIZE) begin
            filter_size = data[FSIZE_W-1:0];
        end else if (idx == CFG_NUM_HASHES) begin
            num_hashes = data[NHASH_W-1:0];
        end
    endtask

    // model: accumulate one byte, settle the key on its last byte
    task automatic apply_key_byte(input logic op, input logic [7:0] kb, input logic last);
        int            span;
        int            probes;
        int            base;
        int            pos;
        bit            all_set;
        bloom_result_t res;
        key_sum = key_sum + kb;
        if (last) begin
            span = (filter_size == 0) ? 1 :
                   (filter_size > FILTER_BITS) ? FILTER_BITS : int'(filter_size);
            probes = (num_hashes > MAX_HASHES) ? MAX_HASHES : int'(num_hashes);
            base = int'(key_sum) % span;
            all_set = 1'b1;
            for (int i = 0; i < probes; i++) begin
                pos = (base + i) % span;
                if (op == OP_ADD) begin
                    filter_bits[pos] = 1'b1;
                end else if (!filter_bits[pos]) begin
                    all_set = 1'b0;
                end
            end
            key_sum = '0;
            res.was_add = (op == OP_ADD);
            res.maybe_present = (op == OP_ADD) ? 1'b0 : all_set;
            pending_results.push_back(res);
        end
    endtask

    // send one key byte request; leaves s_valid high after acceptance
    task automatic send_byte(input logic op, input logic [7:0] kb, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_key_byte  <= kb;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        apply_key_byte(op, kb, last);
    endtask

    // register write request
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg_write(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // both registers, unused upper data bits randomized
    task automatic set_filter(input int span, input int probes);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom());
        data[FSIZE_W-1:0] = FSIZE_W'(span);
        write_reg(CFG_FILTER_SIZE, data);
        data = CFG_DATA_W'($urandom());
        data[NHASH_W-1:0] = NHASH_W'(probes);
        write_reg(CFG_NUM_HASHES, data);
    endtask

    // wait until every result is in and the block has gone quiet
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // key of random bytes; the selector on earlier bytes is noise
    task automatic send_random_key(input logic op, input int len, output int total);
        logic [7:0] kb;
        total = 0;
        for (int i = 0; i < len; i++) begin
            kb = 8'($urandom());
            total += kb;
            send_byte((i == len - 1) ? op : 1'($urandom()), kb, i == len - 1);
        end
    endtask

    // key with a chosen byte sum, split at random
    task automatic send_key_summing(input logic op, input int target);
        int         remain;
        logic [7:0] kb;
        remain = target;
        while (remain > 255) begin
            kb = 8'($urandom_range(1, 255));
            remain -= kb;
            send_byte(1'($urandom()), kb, 1'b0);
        end
        send_byte(op, 8'(remain), 1'b1);
    endtask

    // reset values: empty store, size 100, three probes
    task automatic test_reset_state();
        send_byte(OP_QUERY, 8'd65, 1'b1);
        send_byte(OP_ADD, 8'd200, 1'b1);
        send_byte(OP_QUERY, 8'd100, 1'b1);
        send_byte(OP_QUERY, 8'd0, 1'b0);
        send_byte(OP_QUERY, 8'd0, 1'b1);
        send_byte(OP_QUERY, 8'd255, 1'b0);
        send_byte(OP_ADD, 8'd0, 1'b1);
        send_byte(OP_QUERY, 8'd155, 1'b1);
        send_byte(OP_QUERY, 8'd3, 1'b1);
    endtask

    // size and probe count at and beyond their limits, unused index
    task automatic test_probe_extremes();
        wait_idle();
        set_filter(0, 15);
        write_reg(CFG_FIRST_UNUSED, 16'hffff);
        send_byte(OP_ADD, 8'd7, 1'b1);
        send_byte(OP_QUERY, 8'd255, 1'b1);
        wait_idle();
        set_filter(511, 0);
        send_byte(OP_QUERY, 8'd123, 1'b1);
        send_byte(OP_ADD, 8'd123, 1'b1);
        wait_idle();
        write_reg(CFG_NUM_HASHES, 16'd1);
        send_byte(OP_QUERY, 8'd123, 1'b1);
        wait_idle();
        set_filter(256, 8);
        write_reg(8'hff, 16'h0000);
        send_byte(OP_ADD, 8'd252, 1'b1);
        send_byte(OP_QUERY, 8'd255, 1'b1);
        send_byte(OP_QUERY, 8'd254, 1'b1);
        wait_idle();
        set_filter(257, 2);
        send_byte(OP_QUERY, 8'd2, 1'b1);
    endtask

    // bits beyond a shrunk size survive until it grows again
    task automatic test_size_shrink();
        wait_idle();
        set_filter(256, 4);
        send_byte(OP_ADD, 8'd250, 1'b1);
        wait_idle();
        set_filter(16, 4);
        send_byte(OP_QUERY, 8'd250, 1'b1);
        send_byte(OP_ADD, 8'd250, 1'b1);
        wait_idle();
        set_filter(256, 4);
        send_byte(OP_QUERY, 8'd250, 1'b1);
        send_byte(OP_QUERY, 8'd10, 1'b1);
    endtask

    // phases of random keys under random settings
    task automatic test_random_keys();
        int start;
        int phase;
        int phase_end;
        int span;
        int total;
        int pick;
        start = bytes_sent;
        phase = 0;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0: span = 0;
                1: span = 1;
                2: span = FILTER_BITS;
                3: span = 511;
                4: span = $urandom_range(FILTER_BITS + 1, 511);
                default: span = $urandom_range(2, 64);
            endcase
            set_filter(span, $urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, 255)),
                          CFG_DATA_W'($urandom()));
            end
            steady = (phase == 2);
            added_sums.delete();
            phase_end = bytes_sent + $urandom_range(60, 140);
            while (bytes_sent < phase_end && bytes_sent - start < RANDOM_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 50 || added_sums.size() == 0) begin
                    send_random_key(OP_ADD,
                                    ($urandom_range(9) == 0) ? $urandom_range(7, 40)
                                                             : $urandom_range(1, 6),
                                    total);
                    added_sums.push_back(total);
                end else if (pick < 80) begin
                    send_key_summing(OP_QUERY,
                                     added_sums[$urandom_range(0, added_sums.size() - 1)]);
                end else begin
                    send_random_key(OP_QUERY, $urandom_range(1, 6), total);
                end
            end
            phase++;
        end
        steady = 1'b0;
    endtask

    // sequence
    initial begin
        error_count = 0;
        bytes_sent  = 0;
        steady      = 1'b0;
        filter_bits = '0;
        key_sum     = '0;
        filter_size = FSIZE_RESET;
        num_hashes  = NHASH_RESET;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_operation <= OP_ADD;
        s_key_byte  <= '0;
        s_last_byte <= 1'b0;
        m_ready     <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // store clearing pass holds s_ready low
        while (!s_ready) @(posedge aclk);

        test_reset_state();
        test_probe_extremes();
        test_size_shrink();
        test_random_keys();

        wait_idle();
        if (error_count == 0) begin
            $display("bloom_filter_byte_sum_unit_tb passed");
        end else begin
            $display("bloom_filter_byte_sum_unit_tb failed");
        end
        $finish;
    end

endmodule
